// ===== rtl/mfr_pkg.sv =====
// Shared types and constants for the monochrome frame store line rasterizer.
// Holds command, status and memory-operation codes plus the request struct.
// No dependencies.
`default_nettype none

package mfr_pkg;

  localparam int CMD_W    = 3;
  localparam int COORD_W  = 8;
  localparam int RADDR_W  = 10;
  localparam int STATUS_W = 2;
  localparam int BYTE_W   = 8;

  localparam logic [CMD_W-1:0] CMD_PLOT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LINE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INVERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOINIT  = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;
  localparam logic [2:0]        ROW_MASK   = 3'h7;

  typedef enum logic [2:0] {
    OP_SET  = 3'd0,
    OP_CLR  = 3'd1,
    OP_INV  = 3'd2,
    OP_FILL = 3'd3,
    OP_READ = 3'd4
  } mfr_op_t;

  typedef struct packed {
    logic              valid;
    mfr_op_t           op;
    logic [BYTE_W-1:0] mask;
  } mfr_req_t;

endpackage

`default_nettype wire

// ===== rtl/mfr_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
// Depends on mfr_pkg for field widths.
`default_nettype none

interface mfr_in_if;
  import mfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [COORD_W-1:0]  x_start;
  logic [COORD_W-1:0]  y_start;
  logic [COORD_W-1:0]  x_end;
  logic [COORD_W-1:0]  y_end;
  logic                color;
  logic [RADDR_W-1:0]  read_address;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, color, read_address,
                  input ready);
  modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, color, read_address,
                  output ready);
endinterface

interface mfr_out_if;
  import mfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink   (input valid, status, read_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mono_framebuffer_line_raster_top.sv =====
// Top level: command sequencer, config register and result register.
// Depends on mfr_pkg, mfr_if, mfr_line and mfr_rmw.
//
//  Channel  Direction  Handshake            Payload
//  in_ch    in         valid/ready          cmd, x_start, y_start, x_end, y_end, color,
//                                           read_address
//  out_ch   out        valid/ready          status, read_data
//  APB      in         psel/penable/pready  paddr[2:0], pwdata, prdata (ready_cfg at 0)
//
// Plot runs through the draw, drain and done states and read through drain and done;
// done loads the result register. A line draws max(dx,dy)+1 pixels in the draw state;
// fill and invert sweep all W*ceil(H/8) store bytes. Each memory op is one issue slot
// of the read-modify-write stage. After reset a clearing pass zeroes every store byte
// with in_ch.ready low. A stalled result holds in out_ch; the next command is taken.
`default_nettype none

module mono_framebuffer_line_raster_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mfr_in_if.sink           in_ch,
  mfr_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mfr_pkg::*;

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(BYTES);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(BYTES - 1);
  localparam logic [RADDR_W+2:0] BYTES_LIM = (RADDR_W+3)'(BYTES);
  localparam logic [COORD_W:0]   W_LIM     = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic [COORD_W:0]   H_LIM     = (COORD_W+1)'(SCREEN_HEIGHT);
  localparam logic [AW-1:0]      W_STRIDE  = AW'(SCREEN_WIDTH);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DRAW  = 6'b000100,
    S_SWEEP = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic                invert_r, invert_nxt;
  logic                ready_cfg_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [BYTE_W-1:0]   out_data_r;
  mfr_op_t             sweep_op_r, sweep_op_nxt;
  logic [BYTE_W-1:0]   fill_byte_r, fill_byte_nxt;
  logic                pix_set_r, pix_set_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic                rd_pend_r, rd_pend_nxt;

  logic                in_acc, out_free, cfg_wr;
  logic                plot_off, read_off;
  logic                line_load, line_last;
  logic [COORD_W-1:0]  pix_x, pix_y, lx1, ly1;
  logic [AW-1:0]       pix_addr;
  mfr_req_t            req;
  logic [AW-1:0]       req_addr;
  logic [BYTE_W-1:0]   rd_byte;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {31'd0, ready_cfg_r};

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_data_r;

  assign plot_off = ({1'b0, in_ch.x_start} >= W_LIM) || ({1'b0, in_ch.y_start} >= H_LIM);
  assign read_off = ({3'd0, in_ch.read_address} >= BYTES_LIM);

  assign line_load = in_acc && (((in_ch.cmd == CMD_PLOT) && !plot_off) ||
                                (in_ch.cmd == CMD_LINE));
  assign lx1 = (in_ch.cmd == CMD_LINE) ? in_ch.x_end : in_ch.x_start;
  assign ly1 = (in_ch.cmd == CMD_LINE) ? in_ch.y_end : in_ch.y_start;

  mfr_line #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (line_load),
    .adv     (state_r == S_DRAW),
    .x0_i    (in_ch.x_start),
    .y0_i    (in_ch.y_start),
    .x1_i    (lx1),
    .y1_i    (ly1),
    .pix_x_o (pix_x),
    .pix_y_o (pix_y),
    .last_o  (line_last)
  );

  assign pix_addr = AW'(pix_x) + AW'(AW'(pix_y[COORD_W-1:3]) * W_STRIDE);

  mfr_rmw #(.DEPTH(BYTES)) u_rmw (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (req),
    .addr_i    (req_addr),
    .rd_byte_o (rd_byte)
  );

  always_comb begin
    req      = '0;
    req_addr = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        req.valid = 1'b1;
        req.op    = OP_FILL;
        req.mask  = BYTE_ZEROS;
      end
      S_SWEEP: begin
        req.valid = 1'b1;
        req.op    = sweep_op_r;
        req.mask  = fill_byte_r;
      end
      S_DRAW: begin
        req.valid = 1'b1;
        req.op    = pix_set_r ? OP_SET : OP_CLR;
        req.mask  = BYTE_W'(1) << (pix_y[2:0] & ROW_MASK);
        req_addr  = pix_addr;
      end
      S_IDLE: begin
        req.valid = in_acc && (in_ch.cmd == CMD_READ) && ready_cfg_r && !read_off;
        req.op    = OP_READ;
        req_addr  = AW'(in_ch.read_address);
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    invert_nxt    = invert_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    sweep_op_nxt  = sweep_op_r;
    fill_byte_nxt = fill_byte_r;
    pix_set_nxt   = pix_set_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    rd_pend_nxt   = rd_pend_r;
    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          status_nxt  = STS_OK;
          data_nxt    = BYTE_ZEROS;
          rd_pend_nxt = 1'b0;
          pix_set_nxt = in_ch.color ^ invert_r;
          cnt_nxt     = '0;
          case (in_ch.cmd)
            CMD_PLOT: begin
              if (plot_off) begin
                status_nxt = STS_INVALID;
                state_nxt  = S_DONE;
              end else begin
                state_nxt  = S_DRAW;
              end
            end
            CMD_LINE: state_nxt = S_DRAW;
            CMD_FILL, CMD_INVERT: begin
              if (!ready_cfg_r) begin
                status_nxt = STS_NOINIT;
                state_nxt  = S_DONE;
              end else begin
                state_nxt     = S_SWEEP;
                sweep_op_nxt  = (in_ch.cmd == CMD_FILL) ? OP_FILL : OP_INV;
                fill_byte_nxt = in_ch.color ? BYTE_ONES : BYTE_ZEROS;
                invert_nxt    = invert_r ^ (in_ch.cmd == CMD_INVERT);
              end
            end
            CMD_READ: begin
              if (!ready_cfg_r) begin
                status_nxt = STS_NOINIT;
                state_nxt  = S_DONE;
              end else if (read_off) begin
                status_nxt = STS_INVALID;
                state_nxt  = S_DONE;
              end else begin
                rd_pend_nxt = 1'b1;
                state_nxt   = S_DRAIN;
              end
            end
            default: begin
              status_nxt = STS_INVALID;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_DRAW: begin
        if (line_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (rd_pend_r) begin
          data_nxt = rd_byte;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      invert_r    <= 1'b0;
      ready_cfg_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      invert_r    <= invert_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      if (cfg_wr) begin
        ready_cfg_r <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sweep_op_r  <= sweep_op_nxt;
    fill_byte_r <= fill_byte_nxt;
    pix_set_r   <= pix_set_nxt;
    status_r    <= status_nxt;
    data_r      <= data_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= status_r;
      out_data_r   <= data_r;
    end
  end

  a_pix_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW) |-> (({1'b0, pix_x} < W_LIM) && ({1'b0, pix_y} < H_LIM)))
    else $error("line stepper left the screen");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_read_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r != STS_OK) |-> (data_r == BYTE_ZEROS))
    else $error("read data on failed command");

endmodule

`default_nettype wire

// ===== rtl/mfr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/mfr_rmw.sv =====
// Read-modify-write stage around the frame store RAM, with write forwarding.
// Depends on mfr_pkg and mfr_ram.
`default_nettype none

module mfr_rmw #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mfr_pkg::mfr_req_t        req_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  output logic      [mfr_pkg::BYTE_W-1:0] rd_byte_o
);
  import mfr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  mfr_req_t          mod_req_r;
  logic [AW-1:0]     mod_addr_r;
  logic              fwd_valid_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [BYTE_W-1:0] fwd_data_r;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] wdata;
  logic              we;

  mfr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (mod_addr_r),
    .wdata (wdata),
    .raddr (addr_i),
    .rdata (ram_rdata)
  );

  assign cur_byte = (fwd_valid_r && (fwd_addr_r == mod_addr_r)) ? fwd_data_r : ram_rdata;
  assign we       = mod_req_r.valid && (mod_req_r.op != OP_READ);

  always_comb begin
    case (mod_req_r.op)
      OP_SET:  wdata = cur_byte | mod_req_r.mask;
      OP_CLR:  wdata = cur_byte & ~mod_req_r.mask;
      OP_INV:  wdata = ~cur_byte;
      OP_FILL: wdata = mod_req_r.mask;
      default: wdata = cur_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_req_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      mod_req_r   <= req_i;
      fwd_valid_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    mod_addr_r <= addr_i;
    fwd_addr_r <= mod_addr_r;
    fwd_data_r <= wdata;
  end

  assign rd_byte_o = cur_byte;

endmodule

`default_nettype wire

// ===== rtl/mfr_line.sv =====
// Clamped Bresenham pixel stepper: one pixel position per advance.
// Depends on mfr_pkg for coordinate width.
`default_nettype none

module mfr_line #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire logic                        adv,
  input  wire logic [mfr_pkg::COORD_W-1:0] x0_i,
  input  wire logic [mfr_pkg::COORD_W-1:0] y0_i,
  input  wire logic [mfr_pkg::COORD_W-1:0] x1_i,
  input  wire logic [mfr_pkg::COORD_W-1:0] y1_i,
  output logic      [mfr_pkg::COORD_W-1:0] pix_x_o,
  output logic      [mfr_pkg::COORD_W-1:0] pix_y_o,
  output logic                             last_o
);
  import mfr_pkg::*;

  localparam int ERR_W = 11;
  localparam logic [COORD_W:0]   W_LIM = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic [COORD_W:0]   H_LIM = (COORD_W+1)'(SCREEN_HEIGHT);
  localparam logic [COORD_W-1:0] W_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] H_MAX = COORD_W'(SCREEN_HEIGHT - 1);

  logic [COORD_W-1:0]      x0c, y0c, x1c, y1c, dx_n, dy_n;
  logic [COORD_W:0]        dy_p1, dxdy;
  logic signed [ERR_W-1:0] err_n, err_nxt, dx_s, dy_s;
  logic                    mv_x, mv_y;

  logic [COORD_W-1:0]      x_r, y_r, x1_r, y1_r, dx_r, dy_r;
  logic                    sx_r, sy_r;
  logic signed [ERR_W-1:0] err_r;
  logic [COORD_W:0]        steps_r;

  assign x0c = ({1'b0, x0_i} >= W_LIM) ? W_MAX : x0_i;
  assign x1c = ({1'b0, x1_i} >= W_LIM) ? W_MAX : x1_i;
  assign y0c = ({1'b0, y0_i} >= H_LIM) ? H_MAX : y0_i;
  assign y1c = ({1'b0, y1_i} >= H_LIM) ? H_MAX : y1_i;

  assign dx_n  = (x0c < x1c) ? (x1c - x0c) : (x0c - x1c);
  assign dy_n  = (y0c < y1c) ? (y1c - y0c) : (y0c - y1c);
  assign dy_p1 = {1'b0, dy_n} + (COORD_W+1)'(1);
  assign err_n = (dx_n > dy_n) ?
                 signed'({{(ERR_W-COORD_W+1){1'b0}}, dx_n[COORD_W-1:1]}) :
                 -signed'({{(ERR_W-COORD_W){1'b0}}, dy_p1[COORD_W:1]});

  assign dx_s    = signed'({{(ERR_W-COORD_W){1'b0}}, dx_r});
  assign dy_s    = signed'({{(ERR_W-COORD_W){1'b0}}, dy_r});
  assign mv_x    = err_r > -dx_s;
  assign mv_y    = err_r < dy_s;
  assign err_nxt = err_r - (mv_x ? dy_s : '0) + (mv_y ? dx_s : '0);
  assign dxdy    = {1'b0, dx_r} + {1'b0, dy_r};

  assign last_o  = ((x_r == x1_r) && (y_r == y1_r)) || (steps_r == dxdy);
  assign pix_x_o = x_r;
  assign pix_y_o = y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
    end else if (load) begin
      steps_r <= '0;
    end else if (adv) begin
      steps_r <= steps_r + (COORD_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r   <= x0c;
      y_r   <= y0c;
      x1_r  <= x1c;
      y1_r  <= y1c;
      dx_r  <= dx_n;
      dy_r  <= dy_n;
      sx_r  <= x0c < x1c;
      sy_r  <= y0c < y1c;
      err_r <= err_n;
    end else if (adv) begin
      err_r <= err_nxt;
      if (mv_x) begin
        x_r <= sx_r ? x_r + COORD_W'(1) : x_r - COORD_W'(1);
      end
      if (mv_y) begin
        y_r <= sy_r ? y_r + COORD_W'(1) : y_r - COORD_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/mfr_raster_checker.sv =====
`timescale 1ns / 1ps
// Checker for the monochrome frame store rasterizer: watches the command, result and APB
// channels, keeps its own copy of the frame store and compares each result in order.
// Depends on mfr_pkg and mfr_if.

module mfr_raster_checker #(
  parameter int         SCREEN_WIDTH  = 128,
  parameter int         SCREEN_HEIGHT = 64,
  parameter logic [2:0] READY_ADDR    = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  mfr_in_if           in_ch,
  mfr_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          results_owed
);
  import mfr_pkg::*;

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_data;
  } raster_result_t;

  raster_result_t    owed_results[$];
  logic [BYTE_W-1:0] pixel_bytes [STORE_BYTES];
  bit                invert_mode;
  bit                display_ready;
  int                mismatches = 0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic plot_pixel(input int x, input int y, input bit color,
                            output logic [STATUS_W-1:0] st);
    int                idx;
    logic [BYTE_W-1:0] bit_mask;
    st = STS_OK;
    if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) begin
      st = STS_INVALID;
    end else begin
      idx = x + (y >>> 3) * SCREEN_WIDTH;
      bit_mask = BYTE_W'(1) << (y[2:0] & ROW_MASK);
      if (idx >= STORE_BYTES) begin
        st = STS_INVALID;
      end else if (color ^ invert_mode) begin
        pixel_bytes[idx] = pixel_bytes[idx] | bit_mask;
      end else begin
        pixel_bytes[idx] = pixel_bytes[idx] & ~bit_mask;
      end
    end
  endtask

  task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                           input bit color);
    int                  dx, dy, sx, sy, err, e2, i, lo, hi, steps;
    logic [STATUS_W-1:0] st;
    if (x0 >= SCREEN_WIDTH)  x0 = SCREEN_WIDTH - 1;
    if (x1 >= SCREEN_WIDTH)  x1 = SCREEN_WIDTH - 1;
    if (y0 >= SCREEN_HEIGHT) y0 = SCREEN_HEIGHT - 1;
    if (y1 >= SCREEN_HEIGHT) y1 = SCREEN_HEIGHT - 1;
    dx = (x0 < x1) ? x1 - x0 : x0 - x1;
    dy = (y0 < y1) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    if (dx == 0) begin
      lo = (y0 < y1) ? y0 : y1;
      hi = (y0 < y1) ? y1 : y0;
      for (i = lo; i <= hi; i++) plot_pixel(x0, i, color, st);
    end else if (dy == 0) begin
      lo = (x0 < x1) ? x0 : x1;
      hi = (x0 < x1) ? x1 : x0;
      for (i = lo; i <= hi; i++) plot_pixel(i, y0, color, st);
    end else begin
      err = (dx > dy) ? dx / 2 : -((dy + 1) / 2);
      for (steps = 0; steps <= dx + dy; steps++) begin
        plot_pixel(x0, y0, color, st);
        if (x0 == x1 && y0 == y1) break;
        e2 = err;
        if (e2 > -dx) begin
          err -= dy;
          x0 += sx;
        end
        if (e2 < dy) begin
          err += dx;
          y0 += sy;
        end
      end
    end
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] cmd,
                                 input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                                 input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                                 input logic color, input logic [RADDR_W-1:0] addr,
                                 output raster_result_t res);
    res.status    = STS_OK;
    res.read_data = BYTE_ZEROS;
    case (cmd)
      CMD_PLOT: plot_pixel(int'(xs), int'(ys), color, res.status);
      CMD_LINE: draw_line(int'(xs), int'(ys), int'(xe), int'(ye), color);
      CMD_FILL: begin
        if (!display_ready) res.status = STS_NOINIT;
        else foreach (pixel_bytes[i]) pixel_bytes[i] = color ? BYTE_ONES : BYTE_ZEROS;
      end
      CMD_INVERT: begin
        if (!display_ready) begin
          res.status = STS_NOINIT;
        end else begin
          foreach (pixel_bytes[i]) pixel_bytes[i] = ~pixel_bytes[i];
          invert_mode = !invert_mode;
        end
      end
      CMD_READ: begin
        if (!display_ready) res.status = STS_NOINIT;
        else if (addr >= STORE_BYTES) res.status = STS_INVALID;
        else res.read_data = pixel_bytes[addr];
      end
      default: res.status = STS_INVALID;
    endcase
  endtask

  always @(posedge clk) begin
    raster_result_t want, got;
    if (!rst_n) begin
      foreach (pixel_bytes[i]) pixel_bytes[i] = BYTE_ZEROS;
      invert_mode   = 1'b0;
      display_ready = 1'b0;
      owed_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing owed: status %0d data %02h",
                                  out_ch.status, out_ch.read_data));
        end else begin
          want = owed_results.pop_front();
          if (out_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
          if (out_ch.read_data !== want.read_data)
            flag_mismatch($sformatf("read_data %02h, want %02h",
                                    out_ch.read_data, want.read_data));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_command(in_ch.cmd, in_ch.x_start, in_ch.y_start, in_ch.x_end, in_ch.y_end,
                        in_ch.color, in_ch.read_address, got);
        owed_results.push_back(got);
      end
      if (psel && penable && pwrite && pready && paddr == READY_ADDR)
        display_ready = pwdata[0];
    end
    mismatch_count <= mismatches;
    results_owed   <= owed_results.size();
  end

endmodule

// ===== tb/sv/mono_framebuffer_line_raster_top_test.sv =====
`timescale 1ns / 1ps
// Top of the frame store rasterizer test: clock, reset, APB writes, command stimulus and
// result back-pressure; the checker beside the block does the comparison.
// Depends on mfr_pkg, mfr_if, mfr_raster_checker and mono_framebuffer_line_raster_top.

module mono_framebuffer_line_raster_top_test;
  import mfr_pkg::*;

  localparam int               SCREEN_WIDTH  = 128;
  localparam int               SCREEN_HEIGHT = 64;
  localparam logic [2:0]       READY_ADDR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam int               IDLE_LIMIT    = 20000;
  localparam int               DRAIN_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        result_ready = 1'b0;
  int          mismatch_count, results_owed;
  int          idle_cycles = 0;
  int          stall_span = 0;
  int          stall_mode = 0;
  int          burst_left = 0;
  bit          valid_high = 1'b0;
  int          last_x = 0;
  int          last_y = 0;

  mfr_in_if  in_ch ();
  mfr_out_if out_ch ();

  assign out_ch.ready = result_ready;

  mono_framebuffer_line_raster_top #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  mfr_raster_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .READY_ADDR   (READY_ADDR)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 400);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       result_ready <= 1'b1;
      1:       result_ready <= 1'($urandom_range(0, 1));
      2:       result_ready <= ($urandom_range(0, 4) == 0);
      default: result_ready <= (stall_span % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(input logic [CMD_W-1:0] cmd,
                       input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                       input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                       input logic color, input logic [RADDR_W-1:0] addr);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.x_start      <= xs;
    in_ch.y_start      <= ys;
    in_ch.x_end        <= xe;
    in_ch.y_end        <= ye;
    in_ch.color        <= color;
    in_ch.read_address <= addr;
    valid_high = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        valid_high = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every owed result has come back
  task automatic settle();
    if (valid_high) begin
      in_ch.valid <= 1'b0;
      valid_high = 1'b0;
    end
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ready(input bit on);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= READY_ADDR;
    pwdata  <= {31'($urandom()), on};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input int span);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return COORD_W'(span - 1);
      2:       return COORD_W'(span);
      3:       return '1;
      4, 5:    return COORD_W'($urandom_range(0, 255));
      default: return COORD_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  task automatic issue_random();
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] xs, ys, xe, ye;
    logic [RADDR_W-1:0] addr;
    int                 roll;
    roll = $urandom_range(0, 99);
    xs   = COORD_W'($urandom());
    ys   = COORD_W'($urandom());
    xe   = COORD_W'($urandom());
    ye   = COORD_W'($urandom());
    addr = RADDR_W'($urandom());
    if (roll < 34) begin
      cmd = CMD_PLOT;
      xs  = pick_coord(SCREEN_WIDTH);
      ys  = pick_coord(SCREEN_HEIGHT);
      if (xs < SCREEN_WIDTH && ys < SCREEN_HEIGHT) begin
        last_x = xs;
        last_y = ys;
      end
    end else if (roll < 64) begin
      cmd = CMD_LINE;
      xs  = pick_coord(SCREEN_WIDTH);
      ys  = pick_coord(SCREEN_HEIGHT);
      xe  = pick_coord(SCREEN_WIDTH);
      ye  = pick_coord(SCREEN_HEIGHT);
      case ($urandom_range(0, 6))
        0:       xe = xs;
        1:       ye = ys;
        default: ;
      endcase
      last_x = (xe >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : xe;
      last_y = (ye >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : ye;
    end else if (roll < 88) begin
      cmd = CMD_READ;
      if ($urandom_range(0, 1)) addr = RADDR_W'((last_y >> 3) * SCREEN_WIDTH + last_x);
    end else if (roll < 91) begin
      cmd = CMD_FILL;
    end else if (roll < 95) begin
      cmd = CMD_INVERT;
    end else begin
      cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end
    issue(cmd, xs, ys, xe, ye, 1'($urandom()), addr);
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_PLOT;
    in_ch.x_start      <= '0;
    in_ch.y_start      <= '0;
    in_ch.x_end        <= '0;
    in_ch.y_end        <= '0;
    in_ch.color        <= 1'b0;
    in_ch.read_address <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // display not yet initialized
    issue(CMD_READ,   0,   0,   0,   0, 1'b0, 10'd0);
    issue(CMD_FILL,   0,   0,   0,   0, 1'b1, 10'd0);
    issue(CMD_INVERT, 0,   0,   0,   0, 1'b0, 10'd0);
    issue(CMD_PLOT,   0,   0,   0,   0, 1'b1, 10'd0);
    issue(CMD_PLOT,   127, 63,  0,   0, 1'b1, 10'd0);
    issue(CMD_PLOT,   128, 0,   0,   0, 1'b1, 10'd0);
    issue(CMD_PLOT,   5,   64,  0,   0, 1'b1, 10'd0);
    issue(CMD_PLOT,   255, 255, 0,   0, 1'b1, 10'd0);
    settle();
    write_ready(1'b1);

    issue(CMD_READ,      0,   0,   0,   0,   1'b0, 10'd0);
    issue(CMD_READ,      0,   0,   0,   0,   1'b0, 10'd1023);
    issue(CMD_LINE,      3,   60,  3,   2,   1'b1, 10'd0);
    issue(CMD_LINE,      100, 10,  20,  10,  1'b1, 10'd0);
    issue(CMD_LINE,      0,   0,   127, 20,  1'b1, 10'd0);
    issue(CMD_LINE,      120, 63,  110, 0,   1'b1, 10'd0);
    issue(CMD_LINE,      255, 255, 200, 0,   1'b1, 10'd0);
    issue(CMD_LINE,      0,   255, 255, 30,  1'b0, 10'd0);
    issue(CMD_LINE,      50,  50,  50,  50,  1'b1, 10'd0);
    issue(CMD_READ,      0,   0,   0,   0,   1'b0, 10'd134);
    issue(CMD_UNUSED_LO, 0,   0,   0,   0,   1'b0, 10'd0);
    issue(CMD_UNUSED_HI, 255, 255, 255, 255, 1'b1, 10'd1023);
    issue(CMD_FILL,      0,   0,   0,   0,   1'b1, 10'd0);
    issue(CMD_INVERT,    0,   0,   0,   0,   1'b0, 10'd0);
    issue(CMD_PLOT,      10,  10,  0,   0,   1'b1, 10'd0);
    issue(CMD_READ,      0,   0,   0,   0,   1'b0, 10'd138);
    issue(CMD_INVERT,    0,   0,   0,   0,   1'b0, 10'd0);
    issue(CMD_READ,      0,   0,   0,   0,   1'b0, 10'd138);
    issue(CMD_FILL,      0,   0,   0,   0,   1'b0, 10'd0);

    repeat (380) begin
      if ($urandom_range(0, 99) == 0) settle();
      issue_random();
    end
    settle();
    write_ready(1'b0);
    repeat (60) issue_random();
    settle();
    write_ready(1'b1);
    repeat (80) issue_random();
    settle();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
